// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TSCB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tscb assertion failed");

// Next-cycle implication.
`define TSCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tscb assertion failed");

`endif

// ===== rtl/core/tscb_pkg.sv =====
// ----------------------------------------------------------------------------
// tscb_pkg
// Shared types, codes and field layout of the text screen cursor buffer.
// ----------------------------------------------------------------------------
package tscb_pkg;

  localparam int OP_W     = 4;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 8;
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 12;
  localparam int H_W      = 6;
  localparam int W_W      = 8;
  localparam int PROD_W   = H_W + W_W;
  localparam int A_W      = PROD_W + 1;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 128;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam int IN_OP_LSB   = 0;
  localparam int IN_ROW_LSB  = 4;
  localparam int IN_COL_LSB  = 10;
  localparam int IN_CHAR_LSB = 18;

  localparam int OUT_CHAR_LSB = 0;
  localparam int OUT_IDX_LSB  = 8;
  localparam int OUT_RERR_BIT = 20;
  localparam int OUT_NULL_BIT = 21;

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_FWD   = 4'd0;
  localparam op_t OP_BACK  = 4'd1;
  localparam op_t OP_UP    = 4'd2;
  localparam op_t OP_DOWN  = 4'd3;
  localparam op_t OP_HOME  = 4'd4;
  localparam op_t OP_END   = 4'd5;
  localparam op_t OP_MOVE  = 4'd6;
  localparam op_t OP_WRITE = 4'd7;
  localparam op_t OP_READ  = 4'd8;
  localparam op_t OP_CLEAR = 4'd9;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_HEIGHT = 1'b0;
  localparam cfg_idx_t CFG_WIDTH  = 1'b1;

  localparam logic [H_W-1:0]    H_RESET    = 6'd24;
  localparam logic [W_W-1:0]    W_RESET    = 8'd80;
  localparam logic [CHAR_W-1:0] FILL_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NULL  = 8'h00;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SIZE,
    ST_CLAMP,
    ST_EXEC,
    ST_WRITE,
    ST_CLEAR,
    ST_READ,
    ST_RESP
  } state_t;

  // Map a raw row count onto 1..maxv.
  function automatic logic [H_W-1:0] eff_height(input logic [H_W-1:0] v, input int maxv);
    logic [H_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = H_W'(1);
    end else if (int'(v) > maxv) begin
      r = H_W'(maxv);
    end
    return r;
  endfunction

  // Map a raw column count onto 1..maxv.
  function automatic logic [W_W-1:0] eff_width(input logic [W_W-1:0] v, input int maxv);
    logic [W_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = W_W'(1);
    end else if (int'(v) > maxv) begin
      r = W_W'(maxv);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/tscb_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tscb_cell_ram
// Single-port character cell store with registered read data.
// ----------------------------------------------------------------------------
module tscb_cell_ram
  import tscb_pkg::*;
#(
  parameter int DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF,
  parameter int AW    = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [AW-1:0]     addr,
  input  logic [CHAR_W-1:0] wdata,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/text_screen_cursor_buffer_top.sv =====
// ----------------------------------------------------------------------------
// text_screen_cursor_buffer_top
// Character screen buffer with one cursor, driven by a command stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transaction (move, write, read at row/col, clear).
//   out_* : exactly one result per command: the cell under the cursor after
//           the command, the linear cursor index and two flags.
//   cfg_* : screen height (index 0) and width (index 1); write only while idle.
// Sequencing:
//   A command runs through SIZE, CLAMP and EXEC, then a WRITE or CLEAR step
//   for a write or a clear, then READ and RESP. in_tready is high again in the
//   same cycle that the result is loaded, so the block takes a new command only
//   once the last is done. The sequencer runs every command through one shared
//   6x8 multiplier (screen size, row offset) and one single-port cell memory.
//   A clear sweeps every cell, one per cycle.
// Reset:
//   After rst_n the block fills all MAX_ROWS*MAX_COLS cells with a space, one
//   per cycle, and holds in_tready low for that whole pass.
// Stall:
//   The result waits in an output register; the next command may still be
//   accepted and run, but it holds in its last step, taking no further
//   command, until out_tready frees the register.
// ----------------------------------------------------------------------------
module text_screen_cursor_buffer_top
  import tscb_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // command stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // op[3:0], target_row[9:4],
                                             // target_col[17:10], char_value[25:18]
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // char_at_cursor[7:0], cursor_index[19:8],
                                             // range_error[20], null_ignored[21]
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CUR_W = (AW < PROD_W) ? AW : PROD_W;

  // control state
  state_t           state_r, state_nxt;
  logic [H_W-1:0]   h_r;
  logic [W_W-1:0]   w_r;
  logic [CUR_W-1:0] cursor_r, cursor_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  op_t                    op_r, op_nxt;
  logic [ROW_W-1:0]       trow_r, trow_nxt;
  logic [COL_W-1:0]       tcol_r, tcol_nxt;
  logic [CHAR_W-1:0]      ch_r, ch_nxt;
  logic [PROD_W-1:0]      mul_r, mul_nxt;
  logic [PROD_W-1:0]      size_r, size_nxt;
  logic                   rerr_r, rerr_nxt;
  logic                   null_r, null_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // shared multiplier and cursor arithmetic
  logic [H_W-1:0]    mul_a;
  logic [PROD_W-1:0] mul_res;
  logic [A_W-1:0]    cur_a, size_a, w_a, span_a, inc_a, abs_a;
  logic              bad_coord;

  // sequencer outputs
  logic              in_acc;
  logic              out_free;
  logic              sweeping;
  logic              clr_done;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_addr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [CHAR_W-1:0] ram_rdata;

  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign sweeping   = (state_r == ST_INIT) || (state_r == ST_CLEAR);
  assign clr_done   = (clr_cnt_r == AW'(CELLS - 1));
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:  if (clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = ST_SIZE;
      ST_SIZE:  state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (op_r == OP_WRITE) begin
          state_nxt = ST_WRITE;
        end else if (op_r == OP_CLEAR) begin
          state_nxt = ST_CLEAR;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_WRITE: state_nxt = ST_READ;
      ST_CLEAR: if (clr_done) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_RESP;
      ST_RESP:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and memory port.
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    ram_re    = (state_r == ST_READ);
    ram_we    = sweeping || ((state_r == ST_WRITE) && (ch_r != CHAR_NULL));
    ram_addr  = sweeping ? clr_cnt_r : AW'(cursor_r);
    ram_wdata = (state_r == ST_INIT) ? FILL_SPACE : ch_r;
  end

  // Shared multiplier: screen size first, then the row offset of the target.
  always_comb begin
    mul_a   = (state_r == ST_SIZE) ? h_r : H_W'(trow_r - ROW_W'(1));
    mul_res = PROD_W'(mul_a) * PROD_W'(w_r);
  end

  // Cursor datapath.
  always_comb begin
    cursor_nxt   = cursor_r;
    op_nxt       = op_r;
    trow_nxt     = trow_r;
    tcol_nxt     = tcol_r;
    ch_nxt       = ch_r;
    mul_nxt      = mul_r;
    size_nxt     = size_r;
    rerr_nxt     = rerr_r;
    null_nxt     = null_r;
    clr_cnt_nxt  = clr_cnt_r;

    cur_a     = A_W'(cursor_r);
    size_a    = A_W'(size_r);
    w_a       = A_W'(w_r);
    span_a    = size_a - w_a;
    inc_a     = cur_a + A_W'(1);
    abs_a     = A_W'(mul_r) + A_W'(tcol_r) - A_W'(1);
    bad_coord = (trow_r == '0) || (H_W'(trow_r) > h_r) || (tcol_r == '0) ||
                (W_W'(tcol_r) > w_r);

    if (sweeping) begin
      clr_cnt_nxt = clr_done ? '0 : clr_cnt_r + AW'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt   = in_tdata[IN_OP_LSB +: OP_W];
          trow_nxt = in_tdata[IN_ROW_LSB +: ROW_W];
          tcol_nxt = in_tdata[IN_COL_LSB +: COL_W];
          ch_nxt   = in_tdata[IN_CHAR_LSB +: CHAR_W];
          rerr_nxt = 1'b0;
          null_nxt = 1'b0;
        end
      end
      ST_SIZE: begin
        mul_nxt = mul_res;
      end
      ST_CLAMP: begin
        // pull a stale cursor back onto the last cell
        size_nxt = mul_r;
        if (cur_a >= A_W'(mul_r)) begin
          cursor_nxt = CUR_W'(A_W'(mul_r) - A_W'(1));
        end
        mul_nxt = mul_res;
      end
      ST_EXEC: begin
        case (op_r)
          OP_FWD: begin
            cursor_nxt = (inc_a >= size_a) ? '0 : CUR_W'(inc_a);
          end
          OP_BACK: begin
            cursor_nxt = (cur_a == '0) ? CUR_W'(size_a - A_W'(1))
                                       : CUR_W'(cur_a - A_W'(1));
          end
          OP_UP: begin
            cursor_nxt = (cur_a < w_a) ? CUR_W'(cur_a + span_a) : CUR_W'(cur_a - w_a);
          end
          OP_DOWN: begin
            cursor_nxt = (cur_a >= span_a) ? CUR_W'(cur_a - span_a) : CUR_W'(cur_a + w_a);
          end
          OP_HOME: begin
            cursor_nxt = '0;
          end
          OP_END: begin
            cursor_nxt = CUR_W'(size_a - A_W'(1));
          end
          OP_MOVE, OP_READ: begin
            if (bad_coord) begin
              rerr_nxt = 1'b1;
            end else begin
              cursor_nxt = CUR_W'(abs_a);
            end
          end
          OP_WRITE: begin
            null_nxt = (ch_r == CHAR_NULL);
          end
          OP_CLEAR: begin
            cursor_nxt = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_RESP) && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[OUT_CHAR_LSB +: CHAR_W] = ram_rdata;
      out_data_nxt[OUT_IDX_LSB +: IDX_W]   = IDX_W'(cursor_r);
      out_data_nxt[OUT_RERR_BIT]           = rerr_r;
      out_data_nxt[OUT_NULL_BIT]           = null_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cursor_r    <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      h_r         <= eff_height(H_RESET, MAX_ROWS);
      w_r         <= eff_width(W_RESET, MAX_COLS);
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      // hold the effective (clamped) sizes
      if (cfg_we && (cfg_index == CFG_HEIGHT)) begin
        h_r <= eff_height(cfg_wdata[H_W-1:0], MAX_ROWS);
      end
      if (cfg_we && (cfg_index == CFG_WIDTH)) begin
        w_r <= eff_width(cfg_wdata[W_W-1:0], MAX_COLS);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    trow_r     <= trow_nxt;
    tcol_r     <= tcol_nxt;
    ch_r       <= ch_nxt;
    mul_r      <= mul_nxt;
    size_r     <= size_nxt;
    rerr_r     <= rerr_nxt;
    null_r     <= null_nxt;
    out_data_r <= out_data_nxt;
  end

  tscb_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/core/tscb_checker.sv =====
// ----------------------------------------------------------------------------
// tscb_checker
// Port-level checks of the text screen cursor buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tscb_checker
  import tscb_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a command is processed alone: no second transaction right behind it
  `TSCB_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // a result is never both a range error and an ignored null write
  `TSCB_ASSERT_IMPL(a_flags_exclusive, out_tvalid,
                    !(out_tdata[OUT_RERR_BIT] && out_tdata[OUT_NULL_BIT]))

  // hold a stalled result
  `TSCB_ASSERT_NEXT(a_out_hold_valid, out_tvalid && !out_tready, out_tvalid)
  `TSCB_ASSERT_NEXT(a_out_hold_data, out_tvalid && !out_tready, $stable(out_tdata))

endmodule

bind text_screen_cursor_buffer_top tscb_checker u_tscb_checker (.*);

// ===== tb/tb_text_screen_cursor_buffer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_screen_cursor_buffer_top
// Self-checking bench for the text screen cursor buffer. A cycle-free screen
// predictor keeps its own cell array, cursor and size registers, and queues
// one expected result per accepted command. A checker compares every result
// transaction field by field. Directed tests cover wrap, range errors, null
// writes, clear and stale cursors; random phases then change the screen size
// and run mixed command traffic with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_text_screen_cursor_buffer_top;
  import tscb_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_WAIT       = 18;
  // long enough for a command other than clear to finish once accepted,
  // with margin on top
  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int CELL_TOTAL     = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int REPORT_LIMIT   = 10;

  // op codes the block leaves unused
  localparam op_t OP_SPARE_FIRST = 4'd10;
  localparam op_t OP_SPARE_LAST  = 4'd15;

  typedef struct {
    logic [CHAR_W-1:0] glyph;
    logic [IDX_W-1:0]  cursor;
    logic              range_err;
    logic              null_ign;
  } screen_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // screen predictor state
  logic [CHAR_W-1:0] screen_cells [CELL_TOTAL];
  int                cursor_at;
  logic [H_W-1:0]    height_reg;
  logic [W_W-1:0]    width_reg;

  screen_result_t expected_screen [$];
  int             mismatch_count;
  bit             src_idle_on;
  bit             snk_idle_on;

  text_screen_cursor_buffer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, clears and reset sweep included.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Rows and columns in use: zero acts as one, oversize clamps to the maximum.
  function automatic int rows_in_use();
    if (height_reg == '0) return 1;
    if (int'(height_reg) > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return int'(height_reg);
  endfunction

  function automatic int cols_in_use();
    if (width_reg == '0) return 1;
    if (int'(width_reg) > MAX_COLS_DEF) return MAX_COLS_DEF;
    return int'(width_reg);
  endfunction

  function automatic int draw_wait(bit enable);
    if (!enable) return 0;
    return int'($urandom_range(0, MAX_WAIT));
  endfunction

  // Apply one command to the predicted screen and return what the block owes.
  function automatic screen_result_t predict_screen_cmd(op_t op, logic [ROW_W-1:0] row,
                                                       logic [COL_W-1:0] col,
                                                       logic [CHAR_W-1:0] ch);
    int rows;
    int cols;
    int cells;
    int cur_row;
    screen_result_t res;
    rows          = rows_in_use();
    cols          = cols_in_use();
    cells         = rows * cols;
    res.range_err = 1'b0;
    res.null_ign  = 1'b0;
    // a size change may leave the cursor off screen: pull it onto the last cell
    if (cursor_at >= cells) cursor_at = cells - 1;
    cur_row = cursor_at / cols;
    case (op)
      OP_FWD:  cursor_at = (cursor_at + 1 >= cells) ? 0 : cursor_at + 1;
      OP_BACK: cursor_at = (cursor_at == 0) ? cells - 1 : cursor_at - 1;
      OP_UP: begin
        if (cur_row == 0) cursor_at = cursor_at + cols * (rows - 1);
        else cursor_at = cursor_at - cols;
      end
      OP_DOWN: begin
        if (cur_row == rows - 1) cursor_at = cursor_at - cols * (rows - 1);
        else cursor_at = cursor_at + cols;
      end
      OP_HOME: cursor_at = 0;
      OP_END:  cursor_at = cells - 1;
      OP_MOVE, OP_READ: begin
        if (int'(row) < 1 || int'(row) > rows || int'(col) < 1 || int'(col) > cols) begin
          res.range_err = 1'b1;
        end else begin
          cursor_at = (int'(row) - 1) * cols + (int'(col) - 1);
        end
      end
      OP_WRITE: begin
        if (ch == CHAR_NULL) res.null_ign = 1'b1;
        else screen_cells[cursor_at] = ch;
      end
      OP_CLEAR: begin
        foreach (screen_cells[i]) screen_cells[i] = ch;
        cursor_at = 0;
      end
      default: ;
    endcase
    res.glyph  = screen_cells[cursor_at];
    res.cursor = IDX_W'(cursor_at);
    return res;
  endfunction

  // Offer one command, hold it until accepted, then queue its expected result.
  task automatic send_cmd(op_t op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                          logic [CHAR_W-1:0] ch);
    int gap;
    logic [IN_TDATA_W-1:0] word;
    gap  = draw_wait(src_idle_on);
    word = '0;
    word[IN_OP_LSB   +: OP_W]   = op;
    word[IN_ROW_LSB  +: ROW_W]  = row;
    word[IN_COL_LSB  +: COL_W]  = col;
    word[IN_CHAR_LSB +: CHAR_W] = ch;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    expected_screen.push_back(predict_screen_cmd(op, row, col, ch));
  endtask

  // Drop valid, wait for every pending result, then let the block go idle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_screen.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program both size registers while the block is idle.
  task automatic set_screen_size(logic [H_W-1:0] h, logic [W_W-1:0] w);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= CFG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we     <= 1'b0;
    height_reg  = h;
    width_reg   = w;
  endtask

  // Result side: stall a random number of cycles before each transaction.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_wait(snk_idle_on);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    screen_result_t got;
    screen_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.glyph     = out_tdata[OUT_CHAR_LSB +: CHAR_W];
      got.cursor    = out_tdata[OUT_IDX_LSB +: IDX_W];
      got.range_err = out_tdata[OUT_RERR_BIT];
      got.null_ign  = out_tdata[OUT_NULL_BIT];
      if (expected_screen.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result with nothing pending: cell %h idx %0d rerr %b null %b",
                   $realtime, got.glyph, got.cursor, got.range_err, got.null_ign);
      end else begin
        want = expected_screen.pop_front();
        if (got.glyph !== want.glyph || got.cursor !== want.cursor ||
            got.range_err !== want.range_err || got.null_ign !== want.null_ign) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"%0t: mismatch: want cell %h idx %0d rerr %b null %b, ",
                      "got cell %h idx %0d rerr %b null %b"}, $realtime,
                     want.glyph, want.cursor, want.range_err, want.null_ign,
                     got.glyph, got.cursor, got.range_err, got.null_ign);
        end
      end
    end
  end

  // Wrap of forward/back over the whole screen, up/down wrap, home and end.
  task automatic test_cursor_wrap();
    send_cmd(OP_BACK, '0, '0, '0);          // from home to the last cell
    send_cmd(OP_FWD,  '1, '1, '1);          // and back across the end
    send_cmd(OP_UP,   '0, '0, '0);          // top row goes to bottom row
    send_cmd(OP_DOWN, '0, '0, '0);          // bottom row goes to top row
    send_cmd(OP_END,  '0, '0, '0);
    send_cmd(OP_HOME, '0, '0, '0);
  endtask

  // Absolute moves and reads, in range and just outside it on every side.
  task automatic test_absolute_range();
    send_cmd(OP_WRITE, '0, '0, 8'hFF);
    send_cmd(OP_WRITE, '0, '0, CHAR_NULL);  // null write must be dropped
    send_cmd(OP_MOVE, ROW_W'(24), COL_W'(80), 8'h00);
    send_cmd(OP_MOVE, ROW_W'(0),  COL_W'(1),  8'h00);
    send_cmd(OP_MOVE, ROW_W'(25), COL_W'(1),  8'h00);
    send_cmd(OP_MOVE, ROW_W'(1),  COL_W'(0),  8'h00);
    send_cmd(OP_MOVE, '1, '1, 8'h00);
    send_cmd(OP_READ, ROW_W'(1),  COL_W'(1),  8'h00);
    send_cmd(OP_READ, ROW_W'(1),  COL_W'(81), 8'h00);
  endtask

  // Unused op codes and a clear with a null fill.
  task automatic test_spare_ops_and_clear();
    send_cmd(OP_SPARE_LAST,  '1, '1, '1);
    send_cmd(OP_SPARE_FIRST, '0, '0, '0);
    send_cmd(OP_CLEAR, '0, '0, CHAR_NULL);
    send_cmd(OP_READ, ROW_W'(2), COL_W'(3), 8'h00);
  endtask

  // Stale cursor after a shrink, register values of zero and above range.
  task automatic test_size_extremes();
    send_cmd(OP_END, '0, '0, '0);
    set_screen_size(H_W'(2), W_W'(3));
    send_cmd(OP_FWD, '0, '0, '0);           // clamp onto last cell, then wrap
    set_screen_size('0, '0);                // acts as one cell
    send_cmd(OP_DOWN, '0, '0, '0);
    send_cmd(OP_UP,   '0, '0, '0);
    set_screen_size('1, '1);                // clamps to the full store
    send_cmd(OP_END, '0, '0, '0);
    send_cmd(OP_CLEAR, '0, '0, FILL_SPACE);
  endtask

  function automatic logic [H_W-1:0] pick_height();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return H_W'(1);
      2:       return H_W'(MAX_ROWS_DEF);
      3:       return '1;
      4:       return H_W'($urandom_range(MAX_ROWS_DEF + 1, (1 << H_W) - 1));
      default: return H_W'($urandom_range(1, MAX_ROWS_DEF));
    endcase
  endfunction

  function automatic logic [W_W-1:0] pick_width();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return W_W'(1);
      2:       return W_W'(MAX_COLS_DEF);
      3:       return '1;
      4:       return W_W'($urandom_range(MAX_COLS_DEF + 1, (1 << W_W) - 1));
      default: return W_W'($urandom_range(1, MAX_COLS_DEF));
    endcase
  endfunction

  // Random traffic in phases; each phase picks a screen size and idle pattern.
  task automatic test_random_traffic();
    int sent;
    int phase_len;
    int pick;
    op_t op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CHAR_W-1:0] ch;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_screen_size(pick_height(), pick_width());
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      phase_len   = $urandom_range(20, 80);
      repeat (phase_len) begin
        pick = $urandom_range(0, 999);
        // clears sweep the whole store, so keep them rare
        if (pick < 15) op = OP_CLEAR;
        else if (pick < 45) op = op_t'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        else op = op_t'(pick % (int'(OP_READ) + 1));
        // mostly legal coordinates so that moves and reads land
        if ($urandom_range(0, 4) != 0) begin
          row = ROW_W'($urandom_range(1, rows_in_use()));
          col = COL_W'($urandom_range(1, cols_in_use()));
        end else begin
          row = ROW_W'($urandom);
          col = COL_W'($urandom);
        end
        ch = ($urandom_range(0, 9) == 0) ? CHAR_NULL : CHAR_W'($urandom);
        send_cmd(op, row, col, ch);
        sent++;
      end
    end
  endtask

  // Main sequence: reset, directed tests, random phases, then drain and judge.
  initial begin
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_HEIGHT;
    cfg_wdata      <= '0;
    rst_n          <= 1'b0;
    mismatch_count  = 0;
    src_idle_on     = 1'b1;
    snk_idle_on     = 1'b1;
    foreach (screen_cells[i]) screen_cells[i] = FILL_SPACE;
    cursor_at  = 0;
    height_reg = H_RESET;
    width_reg  = W_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // in_tready stays low during the reset sweep; send_cmd just waits it out
    test_cursor_wrap();
    test_absolute_range();
    test_spare_ops_and_clear();
    test_size_extremes();
    test_random_traffic();

    drain_results();
    if (mismatch_count == 0 && expected_screen.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
